### rtl/smet_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the sensor grid EMA tracker.
// No dependencies; imported by sensor_matrix_ema_tracker_top.
package smet_pkg;

    // Grid geometry and charge-time full scale
    localparam int GRID_ROWS     = 5;
    localparam int GRID_COLS     = 5;
    localparam int FULL_SCALE_US = 2000;

    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Field widths
    localparam int POS_W   = 3;
    localparam int LEVEL_W = 16;
    localparam int GAIN_W  = 16;
    localparam int TIME_W  = 16;

    localparam logic [POS_W-1:0]  LAST_ROW = POS_W'(GRID_ROWS - 1);
    localparam logic [POS_W-1:0]  LAST_COL = POS_W'(GRID_COLS - 1);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(FULL_SCALE_US);

    // Scaling t*32768/FULL_SCALE_US by reciprocal: q = (t * RECIP) >> (SHIFT - 15),
    // off by at most one below, fixed by one remainder compare.
    localparam int          RECIP_SHIFT = 31;
    localparam logic [31:0] DIV_RECIP   = 32'((64'd1 << RECIP_SHIFT) / FULL_SCALE_US);
    localparam int          QPROD_W     = TIME_W + 32;
    localparam int          QEST_W      = 17;
    localparam int          REM_W       = 34;

    // Register reset values (Q0.16)
    localparam logic [GAIN_W-1:0] RESET_SMOOTH_GAIN = 16'd11796;
    localparam logic [GAIN_W-1:0] RESET_BASE_GAIN   = 16'd66;

    // Item actions; the unused code behaves as a read
    typedef enum logic [1:0] {
        ACT_SAMPLE    = 2'd0,
        ACT_CALIBRATE = 2'd1,
        ACT_READ      = 2'd2
    } t_action;

    // Configuration register indexes
    typedef enum logic {
        CFG_SMOOTH_GAIN = 1'b0,
        CFG_BASE_GAIN   = 1'b1
    } t_cfg_index;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CORR,
        S_EMA,
        S_WRITE,
        S_REPORT,
        S_CAL_RD,
        S_CAL_WR
    } t_state;

    // Row-major cell address
    function automatic logic [CELL_W-1:0] cell_index(input logic [POS_W-1:0] row,
                                                     input logic [POS_W-1:0] col);
        return CELL_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

endpackage

### rtl/sensor_matrix_ema_tracker_top.sv
`timescale 1ns / 1ps
// Sensor grid EMA tracker: per-cell raw, smoothed and baseline levels kept
// in three RAMs with a registered read, driven by a read-modify-write sequencer.
// Depends on smet_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one action per transfer: sample the
//   current scan cell, calibrate all cells, or read one cell. Every item gives
//   exactly one result on the output channel (o_valid / i_stall).
//   Steps per item, in order:
//     sample    RAM read, reciprocal scale, remainder fix, gain multiply,
//               write back
//     read      RAM read and report
//     calibrate sweep of one RAM read and one write per cell
//   One item is in work at a time; o_stall is low only in the idle state out of
//   reset, so a new item is taken while a finished result still waits in the
//   output register.
//   If the receiver stalls, the result holds and the sequencer waits before its
//   write back until the output register is free.
//   Reset (i_rst_n low, synchronous) clears the per-cell valid bits, so every cell
//   reads as zero, returns the scan position to row 0 column 0 and loads the
//   default gains. No RAM clearing pass is needed. The user writes gains through
//   i_cfg_wr_en / i_cfg_index / i_cfg_wdata only while idle; no check enforces it.
module sensor_matrix_ema_tracker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_index,
    input  logic [smet_pkg::GAIN_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_action,
    input  logic [smet_pkg::TIME_W-1:0]   i_charge_time,
    input  logic [smet_pkg::POS_W-1:0]    i_read_row,
    input  logic [smet_pkg::POS_W-1:0]    i_read_col,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [smet_pkg::POS_W-1:0]    o_cell_row,
    output logic [smet_pkg::POS_W-1:0]    o_cell_col,
    output logic [smet_pkg::LEVEL_W-1:0]  o_raw_level,
    output logic [smet_pkg::LEVEL_W-1:0]  o_smoothed_level,
    output logic [smet_pkg::LEVEL_W-1:0]  o_baseline_level
);
    import smet_pkg::*;

    // Sequencer and control
    t_state              r_state, n_state;
    t_action             r_action;
    logic [POS_W-1:0]    r_scan_row, r_scan_col;
    logic [POS_W-1:0]    r_row, r_col;
    logic [CELL_W-1:0]   r_addr;
    logic [CELL_W-1:0]   r_sweep;
    logic [GAIN_W-1:0]   r_smooth_gain, r_base_gain;
    logic                in_xfer, out_free;

    // Arithmetic pipeline registers
    logic [TIME_W-1:0]         r_time;
    logic [QPROD_W-1:0]        r_qprod;
    logic [LEVEL_W-1:0]        r_v;
    logic signed [33:0]        r_prod_s, r_prod_b;

    // RAMs, read data and valid bits
    logic [LEVEL_W-1:0]  raw_mem    [CELLS];
    logic [LEVEL_W-1:0]  smooth_mem [CELLS];
    logic [LEVEL_W-1:0]  base_mem   [CELLS];
    logic [LEVEL_W-1:0]  r_rd_raw, r_rd_smooth, r_rd_base;
    logic                r_rd_vld;
    logic [CELLS-1:0]    r_cell_vld;

    logic                rd_en, wr_sample, wr_cal;
    logic [CELL_W-1:0]   rd_addr, wr_addr;
    logic [LEVEL_W-1:0]  rd_raw, rd_smooth, rd_base;

    // Output register
    logic                r_out_valid;
    logic [POS_W-1:0]    r_out_row, r_out_col;
    logic [LEVEL_W-1:0]  r_out_raw, r_out_smooth, r_out_base;
    logic                out_load;
    logic [LEVEL_W-1:0]  out_raw, out_smooth, out_base;

    // Arithmetic nets
    logic [QEST_W-1:0]   q_est;
    logic [REM_W-1:0]    div_rem;
    logic [LEVEL_W-1:0]  q_fixed;
    logic signed [16:0]  diff_s, diff_b;
    logic [17:0]         sum_s, sum_b;
    logic [LEVEL_W-1:0]  new_smooth, new_base;
    logic [TIME_W-1:0]   time_clamped;
    logic [POS_W-1:0]    rd_row_sat, rd_col_sat;

    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Next state and RAM controls
    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        wr_sample = 1'b0;
        wr_cal    = 1'b0;
        out_load  = 1'b0;
        rd_addr   = r_addr;
        wr_addr   = r_addr;
        o_stall   = (r_state != S_IDLE) || !i_rst_n;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        ACT_SAMPLE:    n_state = S_FETCH;
                        ACT_CALIBRATE: n_state = S_CAL_RD;
                        default:       n_state = S_FETCH;
                    endcase
                end
            end
            S_FETCH: begin
                rd_en   = 1'b1;
                n_state = (r_action == ACT_SAMPLE) ? S_CORR : S_REPORT;
            end
            S_CORR: begin
                n_state = S_EMA;
            end
            S_EMA: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    wr_sample = 1'b1;
                    out_load  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CAL_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_sweep;
                n_state = S_CAL_WR;
            end
            S_CAL_WR: begin
                wr_cal  = 1'b1;
                wr_addr = r_sweep;
                n_state = (r_sweep == LAST_CELL) ? S_FETCH : S_CAL_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_gain <= RESET_SMOOTH_GAIN;
            r_base_gain   <= RESET_BASE_GAIN;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SMOOTH_GAIN: r_smooth_gain <= i_cfg_wdata;
                CFG_BASE_GAIN:   r_base_gain   <= i_cfg_wdata;
                default:         r_base_gain   <= r_base_gain;
            endcase
        end
    end

    // Input capture: clamp time, saturate read coordinates
    assign time_clamped = (i_charge_time > TIME_MAX) ? TIME_MAX : i_charge_time;
    assign rd_row_sat   = (i_read_row > LAST_ROW) ? LAST_ROW : i_read_row;
    assign rd_col_sat   = (i_read_col > LAST_COL) ? LAST_COL : i_read_col;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_time <= time_clamped;
            case (i_action)
                ACT_SAMPLE: begin
                    r_action <= ACT_SAMPLE;
                    r_row    <= r_scan_row;
                    r_col    <= r_scan_col;
                    r_addr   <= cell_index(r_scan_row, r_scan_col);
                end
                ACT_CALIBRATE: begin
                    r_action <= ACT_CALIBRATE;
                    r_row    <= r_scan_row;
                    r_col    <= r_scan_col;
                    r_addr   <= cell_index(r_scan_row, r_scan_col);
                end
                default: begin
                    r_action <= ACT_READ;
                    r_row    <= rd_row_sat;
                    r_col    <= rd_col_sat;
                    r_addr   <= cell_index(rd_row_sat, rd_col_sat);
                end
            endcase
        end
    end

    // Calibration sweep counter
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sweep <= '0;
        end else if (wr_cal && (r_sweep != LAST_CELL)) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    // Scan position: column first, wraps at the grid end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (wr_sample) begin
            if (r_scan_col == LAST_COL) begin
                r_scan_col <= '0;
                r_scan_row <= (r_scan_row == LAST_ROW) ? '0 : r_scan_row + 1'b1;
            end else begin
                r_scan_col <= r_scan_col + 1'b1;
            end
        end
    end

    // Scale: reciprocal product, then one remainder correction
    assign q_est   = QEST_W'(r_qprod >> (RECIP_SHIFT - 15));
    assign div_rem = REM_W'({r_time, 15'b0}) - (REM_W'(q_est) * REM_W'(FULL_SCALE_US));
    assign q_fixed = (div_rem >= REM_W'(FULL_SCALE_US)) ? LEVEL_W'(q_est + 1'b1)
                                                        : LEVEL_W'(q_est);

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_qprod <= QPROD_W'(r_time) * QPROD_W'(DIV_RECIP);
        end
        if (r_state == S_CORR) begin
            r_v <= q_fixed;
        end
    end

    // Cells never written since reset read as zero
    assign rd_raw    = r_rd_vld ? r_rd_raw    : '0;
    assign rd_smooth = r_rd_vld ? r_rd_smooth : '0;
    assign rd_base   = r_rd_vld ? r_rd_base   : '0;

    // EMA step: gain times signed difference, floor by arithmetic shift
    assign diff_s = $signed({1'b0, r_v}) - $signed({1'b0, rd_smooth});
    assign diff_b = $signed({1'b0, r_v}) - $signed({1'b0, rd_base});

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMA) begin
            r_prod_s <= $signed({1'b0, r_smooth_gain}) * diff_s;
            r_prod_b <= $signed({1'b0, r_base_gain}) * diff_b;
        end
    end

    assign sum_s      = {2'b00, rd_smooth} + 18'(r_prod_s[33:16]);
    assign sum_b      = {2'b00, rd_base} + 18'(r_prod_b[33:16]);
    assign new_smooth = sum_s[LEVEL_W-1:0];
    assign new_base   = sum_b[LEVEL_W-1:0];

    // RAMs: one write and one registered read per cycle; the sequencer
    // never overlaps a read and a write of the same cell.
    always_ff @(posedge i_clk) begin
        if (wr_sample) begin
            raw_mem[wr_addr] <= r_v;
        end
        if (rd_en) begin
            r_rd_raw <= raw_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_sample) begin
            smooth_mem[wr_addr] <= new_smooth;
        end else if (wr_cal) begin
            smooth_mem[wr_addr] <= '0;
        end
        if (rd_en) begin
            r_rd_smooth <= smooth_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_sample) begin
            base_mem[wr_addr] <= new_base;
        end else if (wr_cal) begin
            base_mem[wr_addr] <= rd_raw;
        end
        if (rd_en) begin
            r_rd_base <= base_mem[rd_addr];
        end
    end

    // Valid bits per cell; a calibrated but never sampled cell stays all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (wr_sample) begin
                r_cell_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_cell_vld[rd_addr];
            end
        end
    end

    // Result selection: sample reports fresh values, others the stored cell
    assign out_raw    = (r_state == S_WRITE) ? r_v        : rd_raw;
    assign out_smooth = (r_state == S_WRITE) ? new_smooth : rd_smooth;
    assign out_base   = (r_state == S_WRITE) ? new_base   : rd_base;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row    <= r_row;
            r_out_col    <= r_col;
            r_out_raw    <= out_raw;
            r_out_smooth <= out_smooth;
            r_out_base   <= out_base;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_cell_row       = r_out_row;
    assign o_cell_col       = r_out_col;
    assign o_raw_level      = r_out_raw;
    assign o_smoothed_level = r_out_smooth;
    assign o_baseline_level = r_out_base;

endmodule

### dv/sensor_matrix_ema_tracker_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sensor_matrix_ema_tracker_top: sample, calibrate
// and read traffic is checked against a transaction-level model of the grid.
// Depends on smet_pkg and the RTL top level.
module sensor_matrix_ema_tracker_top_tb;
    import smet_pkg::*;

    localparam int CLK_HALF_NS  = 4;
    localparam int STUCK_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_SHOWN    = 10;
    localparam int PHASE_ITEMS  = 380;

    // Action code 3 is outside the package enum; the block treats it as a read
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [1:0]        action;
        logic [TIME_W-1:0] charge_time;
        logic [POS_W-1:0]  read_row;
        logic [POS_W-1:0]  read_col;
    } t_sensor_cmd;

    typedef struct {
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [LEVEL_W-1:0] raw;
        logic [LEVEL_W-1:0] smooth;
        logic [LEVEL_W-1:0] base;
    } t_cell_report;

    // DUT ports; the driven inputs are known from time zero
    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_wr_en      = 1'b0;
    logic                 i_cfg_index      = 1'b0;
    logic [GAIN_W-1:0]    i_cfg_wdata      = '0;
    logic                 i_valid          = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_action         = '0;
    logic [TIME_W-1:0]    i_charge_time    = '0;
    logic [POS_W-1:0]     i_read_row       = '0;
    logic [POS_W-1:0]     i_read_col       = '0;
    logic                 o_valid;
    logic                 i_stall          = 1'b0;
    logic [POS_W-1:0]     o_cell_row;
    logic [POS_W-1:0]     o_cell_col;
    logic [LEVEL_W-1:0]   o_raw_level;
    logic [LEVEL_W-1:0]   o_smoothed_level;
    logic [LEVEL_W-1:0]   o_baseline_level;

    // Stimulus and scoreboard state
    t_sensor_cmd  pending_cmds[$];
    t_cell_report awaited_reports[$];
    t_sensor_cmd  next_cmd;
    t_sensor_cmd  taken_cmd;
    t_cell_report want;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    bit           hold_send      = 1'b0;
    int           mismatch_count = 0;
    int           idle_cycles    = 0;

    // Grid model: per-cell levels, scan position and gains
    logic [LEVEL_W-1:0] raw_lvl    [CELLS];
    logic [LEVEL_W-1:0] smooth_lvl [CELLS];
    logic [LEVEL_W-1:0] base_lvl   [CELLS];
    logic [POS_W-1:0]   scan_r;
    logic [POS_W-1:0]   scan_c;
    logic [GAIN_W-1:0]  smooth_gain;
    logic [GAIN_W-1:0]  base_gain;

    sensor_matrix_ema_tracker_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_charge_time    (i_charge_time),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_cell_row       (o_cell_row),
        .o_cell_col       (o_cell_col),
        .o_raw_level      (o_raw_level),
        .o_smoothed_level (o_smoothed_level),
        .o_baseline_level (o_baseline_level)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // x + floor(g * (v - x) / 2^16); arithmetic shift gives the floor
    function automatic logic [LEVEL_W-1:0] ema_step(input logic [LEVEL_W-1:0] x,
                                                    input logic [LEVEL_W-1:0] v,
                                                    input logic [GAIN_W-1:0] g);
        longint xl;
        longint vl;
        longint gl;
        longint prod;
        xl   = x;
        vl   = v;
        gl   = g;
        prod = gl * (vl - xl);
        return LEVEL_W'(xl + (prod >>> 16));
    endfunction

    // Apply one command to the grid model and return the report it produces
    function automatic t_cell_report apply_sensor_cmd(input t_sensor_cmd cmd);
        t_cell_report       rep;
        longint             t;
        logic [LEVEL_W-1:0] lvl;
        logic [POS_W-1:0]   r;
        logic [POS_W-1:0]   c;
        int                 idx;
        int                 i;
        if (cmd.action == ACT_SAMPLE) begin
            t = cmd.charge_time;
            if (t > FULL_SCALE_US) t = FULL_SCALE_US;
            lvl = LEVEL_W'((t * 32768) / FULL_SCALE_US);
            r   = scan_r;
            c   = scan_c;
            idx = int'(r) * GRID_COLS + int'(c);
            raw_lvl[idx]    = lvl;
            smooth_lvl[idx] = ema_step(smooth_lvl[idx], lvl, smooth_gain);
            base_lvl[idx]   = ema_step(base_lvl[idx], lvl, base_gain);
            // column first, then row, wrapping at the grid end
            if (scan_c == LAST_COL) begin
                scan_c = '0;
                scan_r = (scan_r == LAST_ROW) ? '0 : scan_r + 1'b1;
            end else begin
                scan_c = scan_c + 1'b1;
            end
        end else if (cmd.action == ACT_CALIBRATE) begin
            for (i = 0; i < CELLS; i++) begin
                base_lvl[i]   = raw_lvl[i];
                smooth_lvl[i] = '0;
            end
            r = scan_r;
            c = scan_c;
        end else begin
            // read, including the spare code; indices saturate
            r = (cmd.read_row > LAST_ROW) ? LAST_ROW : cmd.read_row;
            c = (cmd.read_col > LAST_COL) ? LAST_COL : cmd.read_col;
        end
        idx        = int'(r) * GRID_COLS + int'(c);
        rep.row    = r;
        rep.col    = c;
        rep.raw    = raw_lvl[idx];
        rep.smooth = smooth_lvl[idx];
        rep.base   = base_lvl[idx];
        return rep;
    endfunction

    function automatic void flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Driver: issues queued commands, records the prediction on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                taken_cmd.action      = i_action;
                taken_cmd.charge_time = i_charge_time;
                taken_cmd.read_row    = i_read_row;
                taken_cmd.read_col    = i_read_col;
                awaited_reports.push_back(apply_sensor_cmd(taken_cmd));
            end
            if (!i_valid || !o_stall) begin
                if (!hold_send && pending_cmds.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = pending_cmds.pop_front();
                    i_action      <= next_cmd.action;
                    i_charge_time <= next_cmd.charge_time;
                    i_read_row    <= next_cmd.read_row;
                    i_read_col    <= next_cmd.read_col;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (awaited_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result row %0d col %0d raw %0d",
                                            o_cell_row, o_cell_col, o_raw_level));
                end else begin
                    want = awaited_reports.pop_front();
                    if (o_cell_row !== want.row || o_cell_col !== want.col ||
                        o_raw_level !== want.raw || o_smoothed_level !== want.smooth ||
                        o_baseline_level !== want.base) begin
                        flag_mismatch($sformatf(
                            "exp r%0d c%0d raw %0d sm %0d bl %0d, got r%0d c%0d raw %0d sm %0d bl %0d",
                            want.row, want.col, want.raw, want.smooth, want.base,
                            o_cell_row, o_cell_col, o_raw_level, o_smoothed_level,
                            o_baseline_level));
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_cmd(input logic [1:0] action, input logic [TIME_W-1:0] t,
                            input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
        t_sensor_cmd cmd;
        cmd.action      = action;
        cmd.charge_time = t;
        cmd.read_row    = r;
        cmd.read_col    = c;
        pending_cmds.push_back(cmd);
    endtask

    // Mostly samples so the scan wraps and the averages evolve
    task automatic queue_random_cmds(input int count);
        t_sensor_cmd cmd;
        int          pick;
        int          k;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            case ($urandom_range(3))
                0: cmd.charge_time = TIME_W'($urandom);
                1: cmd.charge_time = TIME_W'($urandom_range(2010, 1990));
                default: cmd.charge_time = TIME_W'($urandom_range(FULL_SCALE_US));
            endcase
            cmd.read_row = POS_W'($urandom);
            cmd.read_col = POS_W'($urandom);
            if (pick < 70) cmd.action = ACT_SAMPLE;
            else if (pick < 74) cmd.action = ACT_CALIBRATE;
            else if (pick < 96) cmd.action = ACT_READ;
            else cmd.action = ACT_SPARE;
            pending_cmds.push_back(cmd);
        end
    endtask

    task automatic wait_drain();
        while (pending_cmds.size() != 0 || i_valid || awaited_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Gain write; only called with the block idle
    task automatic write_gain(input t_cfg_index idx, input logic [GAIN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_SMOOTH_GAIN) smooth_gain = value;
        else base_gain = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Main sequence
    initial begin
        for (int i = 0; i < CELLS; i++) begin
            raw_lvl[i]    = '0;
            smooth_lvl[i] = '0;
            base_lvl[i]   = '0;
        end
        scan_r      = '0;
        scan_c      = '0;
        smooth_gain = RESET_SMOOTH_GAIN;
        base_gain   = RESET_BASE_GAIN;
        send_idle_pct = 18;
        recv_idle_pct = 66;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset gains
        push_cmd(ACT_READ,      16'd0,     3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'd0,     3'd7, 3'd7);
        push_cmd(ACT_SAMPLE,    16'd2000,  3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'd2001,  3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'hFFFF,  3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'd1,     3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'd1999,  3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'd1000,  3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'h5555,  3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'h0AAA,  3'd0, 3'd0);
        push_cmd(ACT_READ,      16'hFFFF,  3'd0, 3'd1);
        push_cmd(ACT_READ,      16'd0,     3'd4, 3'd4);
        push_cmd(ACT_READ,      16'd0,     3'd7, 3'd7);
        push_cmd(ACT_READ,      16'd0,     3'd5, 3'd3);
        push_cmd(ACT_READ,      16'd0,     3'd1, 3'd6);
        push_cmd(ACT_SPARE,     16'd0,     3'd6, 3'd1);
        push_cmd(ACT_SPARE,     16'd0,     3'd1, 3'd1);
        push_cmd(ACT_CALIBRATE, 16'hFFFF,  3'd7, 3'd7);
        push_cmd(ACT_READ,      16'd0,     3'd0, 3'd3);
        push_cmd(ACT_SAMPLE,    16'd500,   3'd0, 3'd0);
        push_cmd(ACT_SAMPLE,    16'd1500,  3'd0, 3'd0);
        push_cmd(ACT_CALIBRATE, 16'd0,     3'd0, 3'd0);
        push_cmd(ACT_READ,      16'd0,     3'd1, 3'd0);
        wait_drain();

        // Full smoothing gain, frozen baseline; pause midway for a new setting
        write_gain(CFG_SMOOTH_GAIN, 16'hFFFF);
        write_gain(CFG_BASE_GAIN, 16'h0000);
        queue_random_cmds(PHASE_ITEMS);
        while (pending_cmds.size() > PHASE_ITEMS / 2) @(negedge i_clk);
        hold_send = 1'b1;
        while (i_valid || awaited_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_gain(CFG_SMOOTH_GAIN, GAIN_W'($urandom));
        write_gain(CFG_BASE_GAIN, GAIN_W'($urandom));
        hold_send = 1'b0;
        wait_drain();

        // Frozen smoothing, full baseline gain; sender idles more
        write_gain(CFG_SMOOTH_GAIN, 16'h0000);
        write_gain(CFG_BASE_GAIN, 16'hFFFF);
        send_idle_pct = 66;
        recv_idle_pct = 18;
        queue_random_cmds(PHASE_ITEMS);
        wait_drain();

        // Random gains, no idling on either side
        write_gain(CFG_SMOOTH_GAIN, GAIN_W'($urandom));
        write_gain(CFG_BASE_GAIN, GAIN_W'($urandom_range(1023)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_cmds(PHASE_ITEMS);
        wait_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
